// ===== hw/rtl/emg_lowpass_iir_averager_defines.svh =====
// Assertion macros for the EMG low-pass averager checker.
// Used by emglpf_checker.sv; has no other dependencies.
`ifndef EMG_LOWPASS_IIR_AVERAGER_DEFINES_SVH
`define EMG_LOWPASS_IIR_AVERAGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMGLPF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold starting in the cycle after the antecedent.
`define EMGLPF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/emglpf_pkg.sv =====
// Shared types and constants for the EMG low-pass IIR averager.
// No dependencies; used by the lane, merge and top-level modules.
package emglpf_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W   = 10;
    localparam int SCALE_W    = 24;
    localparam int COEF_W     = 33;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    // Internal datapath widths.
    localparam int X_W   = 34;  // sample times scale, Q.40 unsigned
    localparam int FF_W  = 37;  // feedforward sum 1,3,3,1
    localparam int Y_W   = 64;  // output history, Q23.40 signed
    localparam int ACC_W = 98;  // exact sum of three Q.70 products and feedforward

    localparam logic signed [Y_W-1:0] Y_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [Y_W-1:0] Y_MIN = 64'sh8000_0000_0000_0000;

    // Register reset values.
    localparam logic [SCALE_W-1:0]       INPUT_SCALE_RST = 24'd5420441;
    localparam logic signed [COEF_W-1:0] FB_OLDEST_RST   = 33'sd1066605628;
    localparam logic signed [COEF_W-1:0] FB_MIDDLE_RST   = -33'sd3194280083;
    localparam logic signed [COEF_W-1:0] FB_NEWEST_RST   = 33'sd3201373932;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE = 2'd0,
        CFG_FB_OLDEST   = 2'd1,
        CFG_FB_MIDDLE   = 2'd2,
        CFG_FB_NEWEST   = 2'd3
    } t_cfg_idx;

    // Configuration as seen by every lane.
    typedef struct packed {
        logic [SCALE_W-1:0]       input_scale;
        logic signed [COEF_W-1:0] fb_oldest;
        logic signed [COEF_W-1:0] fb_middle;
        logic signed [COEF_W-1:0] fb_newest;
    } t_cfg;

    // Lane sequencer states: idle, three multiply phases, accumulate, finish one step, last.
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL_OLD,
        LS_MUL_MID,
        LS_MUL_NEW,
        LS_ACC,
        LS_FIN,
        LS_LAST
    } t_lane_state;

endpackage

// ===== hw/rtl/emglpf_lane.sv =====
// One filter lane: third-order IIR with repeated steps on one channel.
// Depends on emglpf_pkg for widths, configuration struct and state type.
module emglpf_lane #(
    parameter int STEPS = 3,
    localparam int SUM_W = 16 + $clog2(STEPS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [emglpf_pkg::SAMPLE_W-1:0]   i_sample,
    input  emglpf_pkg::t_cfg                  i_cfg,
    output logic                              o_done,
    output logic signed [SUM_W-1:0]           o_sum
);

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    emglpf_pkg::t_lane_state r_state, n_state;

    logic [STEP_W-1:0]                        r_step;
    logic                                     r_cvt;
    logic                                     r_done;
    logic [emglpf_pkg::X_W-1:0]               r_x;
    logic [emglpf_pkg::X_W-1:0]               r_xh0;
    logic [emglpf_pkg::X_W-1:0]               r_xh1;
    logic signed [emglpf_pkg::Y_W-1:0]        r_yh [3];
    logic [emglpf_pkg::FF_W-1:0]              r_ff;
    logic signed [emglpf_pkg::ACC_W-1:0]      r_acc;
    logic signed [65:0]                       r_pl;
    logic signed [64:0]                       r_ph;
    logic signed [SUM_W-1:0]                  r_sum;

    logic signed [emglpf_pkg::Y_W-1:0]        mul_y;
    logic signed [emglpf_pkg::COEF_W-1:0]     mul_c;
    logic [emglpf_pkg::X_W+1:0]               pair_sum;
    logic [emglpf_pkg::FF_W-1:0]              ff_calc;
    logic [emglpf_pkg::ACC_W-1:0]             ff_ext;
    logic [emglpf_pkg::ACC_W-1:0]             pl_ext;
    logic [emglpf_pkg::ACC_W-1:0]             ph_ext;
    logic [emglpf_pkg::ACC_W-1:0]             prod;
    logic [emglpf_pkg::ACC_W-31:0]            shifted;
    logic                                     sat_ovf;
    logic signed [emglpf_pkg::Y_W-1:0]        y_new;
    logic                                     y_neg;
    logic [emglpf_pkg::Y_W-1:0]               y_mag;
    logic [23:0]                              y_int;
    logic signed [emglpf_pkg::OUT_W-1:0]      step_out;
    logic                                     start_ok;

    assign start_ok = (r_state == emglpf_pkg::LS_IDLE) && i_start;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= emglpf_pkg::LS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: each filter step runs MUL_OLD, MUL_MID, MUL_NEW, ACC and FIN; LAST folds in the last output.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emglpf_pkg::LS_IDLE: begin
                if (i_start) n_state = emglpf_pkg::LS_MUL_OLD;
            end
            emglpf_pkg::LS_MUL_OLD: n_state = emglpf_pkg::LS_MUL_MID;
            emglpf_pkg::LS_MUL_MID: n_state = emglpf_pkg::LS_MUL_NEW;
            emglpf_pkg::LS_MUL_NEW: n_state = emglpf_pkg::LS_ACC;
            emglpf_pkg::LS_ACC:     n_state = emglpf_pkg::LS_FIN;
            emglpf_pkg::LS_FIN: begin
                n_state = (r_step == LAST_STEP) ? emglpf_pkg::LS_LAST
                                                : emglpf_pkg::LS_MUL_OLD;
            end
            emglpf_pkg::LS_LAST:    n_state = emglpf_pkg::LS_IDLE;
            default:                n_state = emglpf_pkg::LS_IDLE;
        endcase
    end

    // Select which history tap and coefficient feed the multiplier pair.
    always_comb begin
        unique case (r_state)
            emglpf_pkg::LS_MUL_MID: begin
                mul_y = r_yh[1];
                mul_c = i_cfg.fb_middle;
            end
            emglpf_pkg::LS_MUL_NEW: begin
                mul_y = r_yh[2];
                mul_c = i_cfg.fb_newest;
            end
            default: begin
                mul_y = r_yh[0];
                mul_c = i_cfg.fb_oldest;
            end
        endcase
    end

    // Feedforward with taps 1,3,3,1; the two newest inputs are both the current sample.
    always_comb begin
        pair_sum = (emglpf_pkg::X_W+2)'(r_xh1) + (emglpf_pkg::X_W+2)'(r_x);
        ff_calc  = emglpf_pkg::FF_W'(r_xh0) + emglpf_pkg::FF_W'(r_x)
                 + emglpf_pkg::FF_W'(pair_sum) + emglpf_pkg::FF_W'({pair_sum, 1'b0});
    end

    // Align the partial products and feedforward to the accumulator.
    always_comb begin
        ff_ext = {{(emglpf_pkg::ACC_W - emglpf_pkg::FF_W - 30){1'b0}}, r_ff, 30'b0};
        pl_ext = {{(emglpf_pkg::ACC_W - 66){r_pl[65]}}, r_pl};
        ph_ext = {{(emglpf_pkg::ACC_W - 65 - 32){r_ph[64]}}, r_ph, 32'b0};
        prod   = pl_ext + ph_ext;
    end

    // Floor shift by 30 and saturation to the 64-bit history format.
    always_comb begin
        shifted = r_acc[emglpf_pkg::ACC_W-1:30];
        sat_ovf = !(&shifted[67:63]) && (|shifted[67:63]);
        if (sat_ovf) begin
            y_new = shifted[67] ? emglpf_pkg::Y_MIN : emglpf_pkg::Y_MAX;
        end else begin
            y_new = shifted[63:0];
        end
    end

    // Integer part of the newest output, toward zero, clamped to 16 bits.
    always_comb begin
        y_neg = r_yh[2][63];
        y_mag = y_neg ? (64'd0 - r_yh[2]) : r_yh[2];
        y_int = y_mag[63:40];
        if (y_neg) begin
            step_out = (y_int > 24'd32768) ? -16'sd32768 : (16'd0 - y_int[15:0]);
        end else begin
            step_out = (y_int > 24'd32767) ? 16'sd32767 : y_int[15:0];
        end
    end

    // Filter history and step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xh0   <= '0;
            r_xh1   <= '0;
            r_yh[0] <= '0;
            r_yh[1] <= '0;
            r_yh[2] <= '0;
            r_step  <= '0;
            r_cvt   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_cvt  <= (r_state == emglpf_pkg::LS_FIN);
            r_done <= (r_state == emglpf_pkg::LS_LAST);
            if (start_ok) begin
                r_step <= '0;
            end else if (r_state == emglpf_pkg::LS_FIN) begin
                r_xh0   <= r_xh1;
                r_xh1   <= r_x;
                r_yh[0] <= r_yh[1];
                r_yh[1] <= r_yh[2];
                r_yh[2] <= y_new;
                r_step  <= r_step + 1'b1;
            end
        end
    end

    // Products, accumulator and running sum of step outputs.
    always_ff @(posedge i_clk) begin
        r_pl <= $signed({1'b0, mul_y[31:0]}) * mul_c;
        r_ph <= $signed(mul_y[63:32]) * mul_c;

        if (r_state == emglpf_pkg::LS_MUL_OLD) begin
            r_ff <= ff_calc;
        end

        unique case (r_state)
            emglpf_pkg::LS_MUL_MID: r_acc <= ff_ext + prod;
            emglpf_pkg::LS_MUL_NEW,
            emglpf_pkg::LS_ACC:     r_acc <= r_acc + prod;
            default:                r_acc <= r_acc;
        endcase

        if (start_ok) begin
            r_x   <= emglpf_pkg::X_W'(i_sample) * emglpf_pkg::X_W'(i_cfg.input_scale);
            r_sum <= '0;
        end else if (r_cvt) begin
            r_sum <= r_sum + SUM_W'(step_out);
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

// ===== hw/rtl/emglpf_merge.sv =====
// Merge stage: divides both lane sums by the step count and holds the result.
// Depends on emglpf_pkg for the output width.
module emglpf_merge #(
    parameter int STEPS = 3,
    localparam int SUM_W = 16 + $clog2(STEPS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_done,
    input  logic signed [SUM_W-1:0]                i_sum_first,
    input  logic signed [SUM_W-1:0]                i_sum_second,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_first,
    output logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_second,
    output logic                                   o_hold
);

    // Reciprocal scale chosen so that magnitude times RECIP, shifted by K, is exact.
    localparam int K = SUM_W + 3;
    localparam logic [K:0] RECIP =
        (K+1)'(((64'd1 << K) + 64'(STEPS) - 64'd1) / 64'(STEPS));
    localparam int P_W = SUM_W + K + 1;

    logic signed [SUM_W-1:0]              sums [2];
    logic                                 neg  [2];
    logic [SUM_W-1:0]                     mag  [2];
    logic [P_W-1:0]                       prod [2];
    logic                                 r_s1_valid;
    logic                                 r_neg [2];
    logic [emglpf_pkg::OUT_W-1:0]         r_q   [2];
    logic                                 r_out_valid;
    logic [emglpf_pkg::OUT_W-1:0]         r_out [2];
    logic                                 move;

    assign sums[0] = i_sum_first;
    assign sums[1] = i_sum_second;

    // Truncating division on the magnitude of each channel sum.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            neg[c]  = sums[c][SUM_W-1];
            mag[c]  = neg[c] ? (~sums[c] + 1'b1) : sums[c];
            prod[c] = P_W'(mag[c]) * P_W'(RECIP);
        end
    end

    assign move = r_s1_valid && (!r_out_valid || i_ready);

    // Handshake control for the quotient stage and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_done) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Quotient magnitudes, then sign restored into the output register.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            if (i_done) begin
                r_neg[c] <= neg[c];
                r_q[c]   <= prod[c][K+emglpf_pkg::OUT_W-1:K];
            end
            if (move) begin
                r_out[c] <= r_neg[c] ? (16'd0 - r_q[c]) : r_q[c];
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_first  = r_out[0];
    assign o_filtered_second = r_out[1];
    assign o_hold            = r_s1_valid;

endmodule

// ===== hw/rtl/emg_lowpass_iir_averager.sv =====
// A request is taken only while the lanes are idle and the merge stage is empty, so
// the next one waits until the last result is registered, which a stalled output
// can delay. Each of the three filter steps runs on the lane's multiplier pair (three
// taps, accumulate, saturate); then the last step output is folded in, the lanes flag
// done while the merge stage divides, and ready returns as the result is registered.
// Reset (synchronous, active low) clears the history and loads the default registers.
module emg_lowpass_iir_averager #(
    parameter int STEPS_PER_ITEM = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [emglpf_pkg::SAMPLE_W-1:0]        i_sample_first,
    input  logic [emglpf_pkg::SAMPLE_W-1:0]        i_sample_second,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_first,
    output logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_second,
    input  logic                                   i_cfg_wr_en,
    input  logic [emglpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [emglpf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SUM_W = 16 + $clog2(STEPS_PER_ITEM);

    emglpf_pkg::t_cfg        r_cfg;
    logic                    r_busy;
    logic                    accept;
    logic                    done_first;
    logic                    done_second;
    logic                    lanes_done;
    logic                    merge_hold;
    logic signed [SUM_W-1:0] sum_first;
    logic signed [SUM_W-1:0] sum_second;

    assign accept     = i_valid && o_ready;
    assign lanes_done = done_first && done_second;
    assign o_ready    = !r_busy && !merge_hold;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_scale <= emglpf_pkg::INPUT_SCALE_RST;
            r_cfg.fb_oldest   <= emglpf_pkg::FB_OLDEST_RST;
            r_cfg.fb_middle   <= emglpf_pkg::FB_MIDDLE_RST;
            r_cfg.fb_newest   <= emglpf_pkg::FB_NEWEST_RST;
        end else if (i_cfg_wr_en) begin
            unique case (emglpf_pkg::t_cfg_idx'(i_cfg_index))
                emglpf_pkg::CFG_INPUT_SCALE:
                    r_cfg.input_scale <= i_cfg_data[emglpf_pkg::SCALE_W-1:0];
                emglpf_pkg::CFG_FB_OLDEST: r_cfg.fb_oldest <= i_cfg_data;
                emglpf_pkg::CFG_FB_MIDDLE: r_cfg.fb_middle <= i_cfg_data;
                emglpf_pkg::CFG_FB_NEWEST: r_cfg.fb_newest <= i_cfg_data;
            endcase
        end
    end

    // Busy from request accept until the lanes hand their sums to the merge stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (lanes_done) begin
            r_busy <= 1'b0;
        end
    end

    // One lane per channel, running in lockstep.
    emglpf_lane #(
        .STEPS (STEPS_PER_ITEM)
    ) u_lane_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_sample (i_sample_first),
        .i_cfg    (r_cfg),
        .o_done   (done_first),
        .o_sum    (sum_first)
    );

    emglpf_lane #(
        .STEPS (STEPS_PER_ITEM)
    ) u_lane_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_sample (i_sample_second),
        .i_cfg    (r_cfg),
        .o_done   (done_second),
        .o_sum    (sum_second)
    );

    // Averaging and output register.
    emglpf_merge #(
        .STEPS (STEPS_PER_ITEM)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_done            (lanes_done),
        .i_sum_first       (sum_first),
        .i_sum_second      (sum_second),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_filtered_first  (o_filtered_first),
        .o_filtered_second (o_filtered_second),
        .o_hold            (merge_hold)
    );

endmodule

// ===== hw/rtl/emglpf_checker.sv =====
// Port-level checker for the EMG low-pass averager, bound to the top level.
// Depends on emg_lowpass_iir_averager_defines.svh for the assertion macros.
`include "emg_lowpass_iir_averager_defines.svh"

module emglpf_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic [emglpf_pkg::SAMPLE_W-1:0]        i_sample_first,
    input logic [emglpf_pkg::SAMPLE_W-1:0]        i_sample_second,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_first,
    input logic signed [emglpf_pkg::OUT_W-1:0]    o_filtered_second,
    input logic                                   i_cfg_wr_en,
    input logic [emglpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [emglpf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // The filter steps keep the block busy after a request is taken.
    `EMGLPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready ##1 !o_ready ##1 !o_ready, "ready returned too soon after a request")

    // Ready only drops because a request was taken.
    `EMGLPF_ASSERT_NOW(a_ready_drop_cause, i_clk, i_rst_n, $fell(o_ready), $past(i_valid && o_ready), "ready fell without an accepted request")

    // A new result never appears in the cycle right after a request was taken.
    `EMGLPF_ASSERT_NOW(a_result_not_from_accept, i_clk, i_rst_n, $rose(o_valid), !$past(i_valid && o_ready), "result appeared right after a request")

    // A stalled result holds its value.
    `EMGLPF_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_filtered_first) && $stable(o_filtered_second), "stalled result changed")

endmodule

bind emg_lowpass_iir_averager emglpf_checker u_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for emg_lowpass_iir_averager: directed and random sample requests.
// A scoreboard class predicts both channel averages. Depends on emglpf_pkg and the block.

// Predicts the averaged filter output of both channels and checks each result in order.
class averager_scoreboard;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [15:0] second;
    } t_filt_pair;

    localparam int FILTER_STEPS = 3;

    logic [23:0]        input_scale;
    logic signed [32:0] fb_oldest;
    logic signed [32:0] fb_middle;
    logic signed [32:0] fb_newest;
    logic [63:0]        in_hist[6];
    logic signed [63:0] out_hist[6];
    t_filt_pair         expected_pairs[$];
    int                 mismatches;

    function new();
        input_scale = emglpf_pkg::INPUT_SCALE_RST;
        fb_oldest   = emglpf_pkg::FB_OLDEST_RST;
        fb_middle   = emglpf_pkg::FB_MIDDLE_RST;
        fb_newest   = emglpf_pkg::FB_NEWEST_RST;
        for (int i = 0; i < 6; i++) begin
            in_hist[i]  = '0;
            out_hist[i] = '0;
        end
        mismatches = 0;
    endfunction

    // Bits above a register's width are dropped, as in the block.
    function void set_reg(emglpf_pkg::t_cfg_idx idx, logic [32:0] data);
        case (idx)
            emglpf_pkg::CFG_INPUT_SCALE: input_scale = data[23:0];
            emglpf_pkg::CFG_FB_OLDEST:   fb_oldest   = data;
            emglpf_pkg::CFG_FB_MIDDLE:   fb_middle   = data;
            emglpf_pkg::CFG_FB_NEWEST:   fb_newest   = data;
            default: ;
        endcase
    endfunction

    // Runs one channel through all filter steps and returns the truncated average.
    function logic signed [15:0] run_lowpass(int ch, logic [9:0] sample);
        logic [63:0]         x;
        logic [63:0]         x_old;
        logic [63:0]         x_mid;
        logic [63:0]         ff;
        logic [63:0]         mag;
        logic [63:0]         whole;
        logic signed [127:0] acc;
        logic signed [127:0] hist;
        logic signed [127:0] coef;
        logic signed [127:0] shifted;
        logic signed [63:0]  y;
        int                  step_out;
        int                  step_sum;
        int                  base;
        base     = ch * 3;
        step_sum = 0;
        x = sample * input_scale;
        in_hist[base + 2] = x;
        for (int k = 0; k < FILTER_STEPS; k++) begin
            x_old = in_hist[base];
            x_mid = in_hist[base + 1];
            in_hist[base]     = x_mid;
            in_hist[base + 1] = x;
            in_hist[base + 2] = x;
            // Feedforward taps 1,3,3,1, aligned to the Q.70 product scale.
            ff  = x_old + x + 3 * (x_mid + x);
            acc = {64'd0, ff};
            acc = acc <<< 30;
            hist = out_hist[base];
            coef = fb_oldest;
            acc  = acc + hist * coef;
            hist = out_hist[base + 1];
            coef = fb_middle;
            acc  = acc + hist * coef;
            hist = out_hist[base + 2];
            coef = fb_newest;
            acc  = acc + hist * coef;
            // Floor shift back to Q.40, then clamp to the 64-bit history range.
            shifted = acc >>> 30;
            if (shifted[127:63] != {65{shifted[63]}}) begin
                y = shifted[127] ? emglpf_pkg::Y_MIN : emglpf_pkg::Y_MAX;
            end else begin
                y = shifted[63:0];
            end
            out_hist[base]     = out_hist[base + 1];
            out_hist[base + 1] = out_hist[base + 2];
            out_hist[base + 2] = y;
            // Integer part truncated toward zero and clamped to int16.
            mag   = y[63] ? (~y + 64'd1) : y;
            whole = mag >> 40;
            if (y[63]) begin
                step_out = (whole > 32768) ? -32768 : -int'(whole);
            end else begin
                step_out = (whole > 32767) ? 32767 : int'(whole);
            end
            step_sum += step_out;
        end
        return 16'(step_sum / FILTER_STEPS);
    endfunction

    function void note_request(logic [9:0] first, logic [9:0] second);
        t_filt_pair pair;
        pair.first  = run_lowpass(0, first);
        pair.second = run_lowpass(1, second);
        expected_pairs.push_back(pair);
    endfunction

    function int pending();
        return expected_pairs.size();
    endfunction

    // Prints one line per mismatch and counts it.
    task report(string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    task check_result(logic signed [15:0] first, logic signed [15:0] second);
        t_filt_pair want;
        if (expected_pairs.size() == 0) begin
            report($sformatf("result %0d,%0d with no request pending", first, second));
            return;
        end
        want = expected_pairs.pop_front();
        if (first !== want.first) begin
            report($sformatf("filtered_first got %0d want %0d", first, want.first));
        end
        if (second !== want.second) begin
            report($sformatf("filtered_second got %0d want %0d", second, want.second));
        end
    endtask

endclass

module tb_top;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 158;
    localparam int SETTLE       = 24;

    typedef enum int {
        SET_DEFAULT,
        SET_SCALE_MAX,
        SET_SCALE_ZERO,
        SET_NEAR_DEFAULT,
        SET_FB_MAX,
        SET_FB_MIN,
        SET_RANDOM,
        SET_FIR_ONLY
    } t_setting;

    logic                                      i_clk = 1'b0;
    logic                                      i_rst_n;
    logic                                      i_valid;
    logic                                      o_ready;
    logic [emglpf_pkg::SAMPLE_W-1:0]           i_sample_first;
    logic [emglpf_pkg::SAMPLE_W-1:0]           i_sample_second;
    logic                                      o_valid;
    logic                                      i_ready = 1'b0;
    logic signed [emglpf_pkg::OUT_W-1:0]       o_filtered_first;
    logic signed [emglpf_pkg::OUT_W-1:0]       o_filtered_second;
    logic                                      i_cfg_wr_en;
    emglpf_pkg::t_cfg_idx                      i_cfg_index;
    logic [emglpf_pkg::CFG_DATA_W-1:0]         i_cfg_data;

    averager_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned rx_stall_left = 0;
    bit          rx_throttle = 1'b1;
    bit          tx_throttle = 1'b1;

    emg_lowpass_iir_averager i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_first    (i_sample_first),
        .i_sample_second   (i_sample_second),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_filtered_first  (o_filtered_first),
        .o_filtered_second (o_filtered_second),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    always @(posedge i_clk) begin
        int unsigned gap;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            i_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            gap = pick_gap(!rx_throttle);
            if (gap != 0) begin
                i_ready       <= 1'b0;
                rx_stall_left <= gap - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watch both handshakes: predict on each accepted request, check each result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result(o_filtered_first, o_filtered_second);
            end
            if (i_valid && o_ready) begin
                sb.note_request(i_sample_first, i_sample_second);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one request and waits for acceptance; valid stays high when no gap follows.
    task automatic send_samples(logic [9:0] first, logic [9:0] second);
        int unsigned gap;
        gap = pick_gap(!tx_throttle);
        i_valid         <= 1'b1;
        i_sample_first  <= first;
        i_sample_second <= second;
        do @(posedge i_clk); while (!o_ready);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the last register.
    task automatic write_reg(emglpf_pkg::t_cfg_idx idx, logic [32:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Wait for every result, let the pipeline settle, then rewrite all registers.
    task automatic apply_setting(t_setting kind);
        logic [32:0] scale_word;
        logic [32:0] fo;
        logic [32:0] fm;
        logic [32:0] fn;
        logic [32:0] nudge;
        // Wait for a clock edge first so that the last accepted request is already noted.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        // Upper data bits are random; the scale register keeps only its low 24.
        scale_word = {9'($urandom), 24'($urandom)};
        fo = emglpf_pkg::FB_OLDEST_RST;
        fm = emglpf_pkg::FB_MIDDLE_RST;
        fn = emglpf_pkg::FB_NEWEST_RST;
        case (kind)
            SET_DEFAULT:    scale_word[23:0] = emglpf_pkg::INPUT_SCALE_RST;
            SET_SCALE_MAX:  scale_word[23:0] = 24'hFF_FFFF;
            SET_SCALE_ZERO: scale_word[23:0] = 24'd0;
            SET_NEAR_DEFAULT: begin
                nudge = 33'($urandom_range(0, 131072)) - 33'd65536;
                fo    = fo + nudge;
                nudge = 33'($urandom_range(0, 131072)) - 33'd65536;
                fm    = fm + nudge;
                nudge = 33'($urandom_range(0, 131072)) - 33'd65536;
                fn    = fn + nudge;
            end
            SET_FB_MAX: begin
                fo = 33'h0_FFFF_FFFF;
                fm = 33'h0_FFFF_FFFF;
                fn = 33'h0_FFFF_FFFF;
            end
            SET_FB_MIN: begin
                fo = 33'h1_0000_0000;
                fm = 33'h1_0000_0000;
                fn = 33'h1_0000_0000;
            end
            SET_RANDOM: begin
                fo = {1'($urandom), 32'($urandom)};
                fm = {1'($urandom), 32'($urandom)};
                fn = {1'($urandom), 32'($urandom)};
            end
            SET_FIR_ONLY: begin
                fo = '0;
                fm = '0;
                fn = '0;
            end
            default: ;
        endcase
        write_reg(emglpf_pkg::CFG_INPUT_SCALE, scale_word);
        write_reg(emglpf_pkg::CFG_FB_OLDEST, fo);
        write_reg(emglpf_pkg::CFG_FB_MIDDLE, fm);
        write_reg(emglpf_pkg::CFG_FB_NEWEST, fn);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned reps;
        int unsigned r;
        logic [9:0]  a;
        logic [9:0]  b;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample_first  = '0;
        i_sample_second = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = emglpf_pkg::CFG_INPUT_SCALE;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests on the reset settings: extremes, steps and repeats.
        send_samples(10'd0, 10'd0);
        repeat (3) send_samples(10'd1023, 10'd1023);
        send_samples(10'd0, 10'd1023);
        send_samples(10'd1023, 10'd0);
        repeat (2) send_samples(10'd0, 10'd0);
        for (int k = 0; k < 10; k++) begin
            send_samples(10'd1 << k, 10'd1 << (9 - k));
        end
        i_valid <= 1'b0;

        // Random phases, each under a new register setting.
        for (int p = 0; p < PHASES; p++) begin
            apply_setting(t_setting'(p % 8));
            tx_throttle = (p % 3) != 1;
            rx_throttle = (p % 4) != 2;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    // Held sample, as the caller repeats items.
                    a    = 10'($urandom);
                    b    = 10'($urandom);
                    reps = $urandom_range(1, 4);
                end else if (r == 7) begin
                    a    = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    b    = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    reps = $urandom_range(1, 3);
                end else begin
                    a    = 10'($urandom);
                    b    = 10'($urandom);
                    reps = 1;
                end
                repeat (reps) send_samples(a, b);
                sent += reps;
            end
            i_valid <= 1'b0;
        end

        // Drain and allow for any stray result.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE + 16) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
